// File: rtl/core/sbe_pkg.sv
package sbe_pkg;

  // Width of the signed position arithmetic. It covers an 11-bit position
  // plus or minus an 11-bit distance.
  localparam int unsigned PosW = 14;
  localparam int unsigned CntW = 12;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [3:0] {
    OP_SET_LEN  = 4'd0,
    OP_WRITE    = 4'd1,
    OP_READ     = 4'd2,
    OP_DROP_ONE = 4'd3,
    OP_DROP_N   = 4'd4,
    OP_SWAP     = 4'd5,
    OP_UP_EQ    = 4'd6,
    OP_UP_NE    = 4'd7,
    OP_DN_EQ    = 4'd8,
    OP_DN_NE    = 4'd9,
    OP_REVERSE  = 4'd10,
    OP_SHIFT_R  = 4'd11,
    OP_SHIFT_L  = 4'd12
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_COPY,
    S_COPY_WR,
    S_SRCH,
    S_SRCH_CMP,
    S_REV,
    S_SWAP0,
    S_SWAP1,
    S_SWAP2,
    S_SWAP3,
    S_DONE
  } state_e;

  // Zero-extend an 11-bit position or count into the signed domain.
  function automatic pos_t to_pos(logic [10:0] x);
    return pos_t'({3'b000, x});
  endfunction

  // A position is stored only if it lies in 1..cap.
  function automatic logic in_range(pos_t p, int cap);
    return (p > pos_t'(0)) && (int'(p) <= cap);
  endfunction

endpackage

// File: rtl/core/sbe_mem.sv
module sbe_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bounded_sequence_engine.sv
// Channel  Handshake            Payload
// in       in_valid_i/in_stall_o operation_i, index_a_i, index_b_i, amount_i, data_value_i
// out      out_valid_o/out_stall_i found_o, position_o, read_value_o, length_now_o
//
// One item is worked on at a time; the element memory has one read and one write port.
// Set length, write, out-of-range read and unused codes go straight to S_DONE; a read
// passes S_RD_WAIT first, an in-range swap S_SWAP0 to S_SWAP3. Copies (drop, shift) pass
// S_COPY and S_COPY_WR per in-range pair, searches S_SRCH and S_SRCH_CMP per in-range
// position, reverse S_REV and the swap states per pair; skips pass only the first state.
// Reset clears the length and control; element contents are undefined until written.
// A finished item waits until the output register is free, then the next is accepted.
module bounded_sequence_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         operation_i,
  input  logic [10:0]        index_a_i,
  input  logic [10:0]        index_b_i,
  input  logic [10:0]        amount_i,
  input  logic signed [31:0] data_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [10:0]        position_o,
  output logic signed [31:0] read_value_o,
  output logic [10:0]        length_now_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  sbe_pkg::state_e state_q, state_d;
  sbe_pkg::op_e    op_q, op_d;
  sbe_pkg::pos_t   src_q, src_d, dst_q, dst_d;
  sbe_pkg::cnt_t   cnt_q, cnt_d;
  logic            dir_q, dir_d;
  logic [31:0]     val_q, val_d, tmp_q, tmp_d, rd_q, rd_d;
  logic [10:0]     len_q, len_d, pos_q, pos_d;
  logic            found_q, found_d;
  logic            ov_q, ov_d;
  logic            of_q, of_d;
  logic [10:0]     opos_q, opos_d, olen_q, olen_d;
  logic [31:0]     ord_q, ord_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata, mem_rdata;

  sbe_pkg::pos_t   a_p, b_p, amt_p, len_p, diff, n_p, step;
  logic            accept, want_eq, match;

  function automatic logic [AW-1:0] to_addr(sbe_pkg::pos_t p);
    logic [sbe_pkg::PosW-1:0] t;
    t = p - sbe_pkg::pos_t'(1);
    return AW'(t);
  endfunction

  sbe_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != sbe_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign a_p   = sbe_pkg::to_pos(index_a_i);
  assign b_p   = sbe_pkg::to_pos(index_b_i);
  assign amt_p = sbe_pkg::to_pos(amount_i);
  assign len_p = sbe_pkg::to_pos(len_q);
  assign diff  = b_p - a_p + sbe_pkg::pos_t'(1);
  assign n_p   = (sbe_pkg::op_e'(operation_i) == sbe_pkg::OP_DROP_ONE) ?
                 sbe_pkg::pos_t'(1) : amt_p;
  assign step  = dir_q ? sbe_pkg::pos_t'(-1) : sbe_pkg::pos_t'(1);

  assign want_eq = (op_q == sbe_pkg::OP_UP_EQ) || (op_q == sbe_pkg::OP_DN_EQ);
  assign match   = ((mem_rdata == val_q) == want_eq);

  // Sequencer: next state, memory accesses and working registers.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    src_d     = src_q;
    dst_d     = dst_q;
    cnt_d     = cnt_q;
    dir_d     = dir_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    rd_d      = rd_q;
    len_d     = len_q;
    pos_d     = pos_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = to_addr(dst_q);
    mem_wdata = mem_rdata;
    mem_raddr = to_addr(src_q);

    case (state_q)
      sbe_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = sbe_pkg::op_e'(operation_i);
          val_d   = data_value_i;
          rd_d    = '0;
          pos_d   = '0;
          found_d = 1'b0;
          dir_d   = 1'b0;
          cnt_d   = (diff > sbe_pkg::pos_t'(0)) ? sbe_pkg::cnt_t'(diff) : '0;
          state_d = sbe_pkg::S_DONE;
          case (sbe_pkg::op_e'(operation_i))
            sbe_pkg::OP_SET_LEN: begin
              len_d = (int'(amount_i) > CAPACITY) ? 11'(CAPACITY) : amount_i;
            end
            sbe_pkg::OP_WRITE: begin
              if (sbe_pkg::in_range(a_p, CAPACITY)) begin
                mem_we    = 1'b1;
                mem_waddr = to_addr(a_p);
                mem_wdata = data_value_i;
              end
            end
            sbe_pkg::OP_READ: begin
              if (sbe_pkg::in_range(a_p, CAPACITY)) begin
                mem_raddr = to_addr(a_p);
                state_d   = sbe_pkg::S_RD_WAIT;
              end
            end
            sbe_pkg::OP_DROP_ONE, sbe_pkg::OP_DROP_N: begin
              if (n_p != sbe_pkg::pos_t'(0)) begin
                src_d   = n_p + sbe_pkg::pos_t'(1);
                dst_d   = sbe_pkg::pos_t'(1);
                cnt_d   = (len_p > n_p) ? sbe_pkg::cnt_t'(len_p - n_p) : '0;
                len_d   = (n_p >= len_p) ? '0 : 11'(len_p - n_p);
                state_d = sbe_pkg::S_COPY;
              end
            end
            sbe_pkg::OP_SWAP: begin
              src_d = a_p;
              dst_d = b_p;
              if (sbe_pkg::in_range(a_p, CAPACITY) && sbe_pkg::in_range(b_p, CAPACITY)) begin
                state_d = sbe_pkg::S_SWAP0;
              end
            end
            sbe_pkg::OP_UP_EQ, sbe_pkg::OP_UP_NE: begin
              src_d   = a_p;
              pos_d   = 11'(b_p + sbe_pkg::pos_t'(1));
              state_d = sbe_pkg::S_SRCH;
            end
            sbe_pkg::OP_DN_EQ, sbe_pkg::OP_DN_NE: begin
              src_d   = b_p;
              dir_d   = 1'b1;
              pos_d   = 11'(a_p - sbe_pkg::pos_t'(1));
              state_d = sbe_pkg::S_SRCH;
            end
            sbe_pkg::OP_REVERSE: begin
              src_d   = a_p;
              dst_d   = b_p;
              state_d = sbe_pkg::S_REV;
            end
            sbe_pkg::OP_SHIFT_R: begin
              src_d   = b_p;
              dst_d   = b_p + amt_p;
              dir_d   = 1'b1;
              state_d = sbe_pkg::S_COPY;
            end
            sbe_pkg::OP_SHIFT_L: begin
              src_d   = a_p;
              dst_d   = a_p - amt_p;
              state_d = sbe_pkg::S_COPY;
            end
            default: begin
              state_d = sbe_pkg::S_DONE;
            end
          endcase
        end
      end

      sbe_pkg::S_RD_WAIT: begin
        rd_d    = mem_rdata;
        state_d = sbe_pkg::S_DONE;
      end

      // Copy one element per pass; pairs with an end out of range are skipped.
      sbe_pkg::S_COPY: begin
        if (cnt_q == '0) begin
          state_d = sbe_pkg::S_DONE;
        end else if (sbe_pkg::in_range(src_q, CAPACITY) &&
                     sbe_pkg::in_range(dst_q, CAPACITY)) begin
          state_d = sbe_pkg::S_COPY_WR;
        end else begin
          src_d = src_q + step;
          dst_d = dst_q + step;
          cnt_d = cnt_q - sbe_pkg::cnt_t'(1);
        end
      end

      sbe_pkg::S_COPY_WR: begin
        mem_we  = 1'b1;
        src_d   = src_q + step;
        dst_d   = dst_q + step;
        cnt_d   = cnt_q - sbe_pkg::cnt_t'(1);
        state_d = sbe_pkg::S_COPY;
      end

      // Search walks the range and stops at the first match.
      sbe_pkg::S_SRCH: begin
        if (cnt_q == '0) begin
          state_d = sbe_pkg::S_DONE;
        end else if (sbe_pkg::in_range(src_q, CAPACITY)) begin
          state_d = sbe_pkg::S_SRCH_CMP;
        end else begin
          src_d = src_q + step;
          cnt_d = cnt_q - sbe_pkg::cnt_t'(1);
        end
      end

      sbe_pkg::S_SRCH_CMP: begin
        if (match) begin
          found_d = 1'b1;
          pos_d   = 11'(src_q);
          state_d = sbe_pkg::S_DONE;
        end else begin
          src_d   = src_q + step;
          cnt_d   = cnt_q - sbe_pkg::cnt_t'(1);
          state_d = sbe_pkg::S_SRCH;
        end
      end

      // Reverse closes in from both ends, one swap per in-range pair.
      sbe_pkg::S_REV: begin
        if (src_q < dst_q) begin
          if (sbe_pkg::in_range(src_q, CAPACITY) && sbe_pkg::in_range(dst_q, CAPACITY)) begin
            state_d = sbe_pkg::S_SWAP0;
          end else begin
            src_d = src_q + sbe_pkg::pos_t'(1);
            dst_d = dst_q - sbe_pkg::pos_t'(1);
          end
        end else begin
          state_d = sbe_pkg::S_DONE;
        end
      end

      sbe_pkg::S_SWAP0: begin
        state_d = sbe_pkg::S_SWAP1;
      end

      sbe_pkg::S_SWAP1: begin
        mem_raddr = to_addr(dst_q);
        tmp_d     = mem_rdata;
        state_d   = sbe_pkg::S_SWAP2;
      end

      sbe_pkg::S_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(src_q);
        state_d   = sbe_pkg::S_SWAP3;
      end

      sbe_pkg::S_SWAP3: begin
        mem_we    = 1'b1;
        mem_wdata = tmp_q;
        if (op_q == sbe_pkg::OP_REVERSE) begin
          src_d   = src_q + sbe_pkg::pos_t'(1);
          dst_d   = dst_q - sbe_pkg::pos_t'(1);
          state_d = sbe_pkg::S_REV;
        end else begin
          state_d = sbe_pkg::S_DONE;
        end
      end

      sbe_pkg::S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          state_d = sbe_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sbe_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: loaded when the finished item finds the slot free.
  always_comb begin
    ov_d   = ov_q && out_stall_i;
    of_d   = of_q;
    opos_d = opos_q;
    ord_d  = ord_q;
    olen_d = olen_q;
    if ((state_q == sbe_pkg::S_DONE) && (!ov_q || !out_stall_i)) begin
      ov_d   = 1'b1;
      of_d   = found_q;
      opos_d = pos_q;
      ord_d  = rd_q;
      olen_d = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbe_pkg::S_IDLE;
      len_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    cnt_q   <= cnt_d;
    dir_q   <= dir_d;
    val_q   <= val_d;
    tmp_q   <= tmp_d;
    rd_q    <= rd_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    of_q    <= of_d;
    opos_q  <= opos_d;
    ord_q   <= ord_d;
    olen_q  <= olen_d;
  end

  assign out_valid_o  = ov_q;
  assign found_o      = of_q;
  assign position_o   = opos_q;
  assign read_value_o = ord_q;
  assign length_now_o = olen_q;

endmodule

// File: tb/seq_result_checker.sv
`timescale 1ns / 100ps

module seq_result_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [3:0]         operation_i,
  input  logic [10:0]        index_a_i,
  input  logic [10:0]        index_b_i,
  input  logic [10:0]        amount_i,
  input  logic signed [31:0] data_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               found_i,
  input  logic [10:0]        position_i,
  input  logic signed [31:0] read_value_i,
  input  logic [10:0]        length_now_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic        found;
    logic [10:0] position;
    logic [31:0] read_value;
    logic [10:0] length_now;
  } answer_t;

  // Shadow copy of the sequence.
  logic [31:0] shadow_mem [1:CAPACITY];
  int          shadow_len;
  answer_t     pending_answers [$];
  int          fails = 0;
  int          pending_count = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_count;

  function automatic logic stored(int p);
    return (p >= 1) && (p <= CAPACITY);
  endfunction

  function automatic void swap_slots(int p, int q);
    logic [31:0] t;
    if (stored(p) && stored(q)) begin
      t = shadow_mem[p];
      shadow_mem[p] = shadow_mem[q];
      shadow_mem[q] = t;
    end
  endfunction

  function automatic void drop_head(int n);
    if (n != 0) begin
      for (int i = n + 1; i <= shadow_len; i++) shadow_mem[i - n] = shadow_mem[i];
      shadow_len = (n >= shadow_len) ? 0 : shadow_len - n;
    end
  endfunction

  // Applies one operation to the shadow state and returns its answer.
  function automatic answer_t apply_op(logic [3:0] op, int a, int b, int amt,
                                       logic [31:0] v);
    answer_t ans;
    int      p;
    int      i;
    int      j;
    logic    want_eq;
    ans = '0;
    case (sbe_pkg::op_e'(op))
      sbe_pkg::OP_SET_LEN:  shadow_len = (amt > CAPACITY) ? CAPACITY : amt;
      sbe_pkg::OP_WRITE:    if (stored(a)) shadow_mem[a] = v;
      sbe_pkg::OP_READ:     ans.read_value = stored(a) ? shadow_mem[a] : '0;
      sbe_pkg::OP_DROP_ONE: drop_head(1);
      sbe_pkg::OP_DROP_N:   drop_head(amt);
      sbe_pkg::OP_SWAP:     swap_slots(a, b);
      sbe_pkg::OP_UP_EQ, sbe_pkg::OP_UP_NE: begin
        want_eq = (sbe_pkg::op_e'(op) == sbe_pkg::OP_UP_EQ);
        p = b + 1;
        for (int r = a; r <= b; r++) begin
          if (!ans.found && stored(r) && ((shadow_mem[r] == v) == want_eq)) begin
            ans.found = 1'b1;
            p = r;
          end
        end
        ans.position = 11'(p);
      end
      sbe_pkg::OP_DN_EQ, sbe_pkg::OP_DN_NE: begin
        want_eq = (sbe_pkg::op_e'(op) == sbe_pkg::OP_DN_EQ);
        p = a - 1;
        for (int r = b; r >= a; r--) begin
          if (!ans.found && stored(r) && ((shadow_mem[r] == v) == want_eq)) begin
            ans.found = 1'b1;
            p = r;
          end
        end
        ans.position = 11'(p);
      end
      sbe_pkg::OP_REVERSE: begin
        i = a;
        j = b;
        while (i < j) begin
          swap_slots(i, j);
          i++;
          j--;
        end
      end
      sbe_pkg::OP_SHIFT_R: begin
        for (int k = 0; k < b - a + 1; k++) begin
          if (stored(b + amt - k) && stored(b - k))
            shadow_mem[b + amt - k] = shadow_mem[b - k];
        end
      end
      sbe_pkg::OP_SHIFT_L: begin
        for (int k = 0; k < b - a + 1; k++) begin
          if (stored(a - amt + k) && stored(a + k))
            shadow_mem[a - amt + k] = shadow_mem[a + k];
        end
      end
      default: ;
    endcase
    ans.length_now = 11'(shadow_len);
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Predict on every accepted item, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      pending_answers.delete();
      pending_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        pending_answers.push_back(apply_op(operation_i, int'(index_a_i), int'(index_b_i),
                                           int'(amount_i), data_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want = pending_answers.pop_front();
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (position_i !== want.position)
            report_mismatch("position", position_i, want.position);
          if (read_value_i !== want.read_value)
            report_mismatch("read_value", read_value_i, want.read_value);
          if (length_now_i !== want.length_now)
            report_mismatch("length_now", length_now_i, want.length_now);
        end
      end
      pending_count = pending_answers.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int Cap = 1024;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         operation = '0;
  logic [10:0]        index_a = '0;
  logic [10:0]        index_b = '0;
  logic [10:0]        amount = '0;
  logic signed [31:0] data_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic               found;
  logic [10:0]        position;
  logic signed [31:0] read_value;
  logic [10:0]        length_now;
  int                 fail_count;
  int                 pending;

  // Stimulus-side bookkeeping so that no unwritten element is ever read.
  logic               written [1:Cap];
  int                 track_len = 0;
  logic               hold_req = 1'b0;
  logic [31:0]        value_pool [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h5a5a_a5a5};

  bounded_sequence_engine #(.CAPACITY(Cap)) u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .index_a_i(index_a), .index_b_i(index_b),
    .amount_i(amount), .data_value_i(data_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .position_o(position), .read_value_o(read_value),
    .length_now_o(length_now)
  );

  seq_result_checker #(.CAPACITY(Cap)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .index_a_i(index_a), .index_b_i(index_b),
    .amount_i(amount), .data_value_i(data_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .found_i(found), .position_i(position), .read_value_i(read_value),
    .length_now_i(length_now),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL bounded_sequence_engine");
    $finish;
  end

  function automatic logic stored(int p);
    return (p >= 1) && (p <= Cap);
  endfunction

  function automatic logic span_written(int lo, int hi);
    for (int p = (lo < 1 ? 1 : lo); p <= hi && p <= Cap; p++) begin
      if (!written[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // True when the operation reads only elements that have been written.
  function automatic logic reads_ok(logic [3:0] op, int a, int b, int amt);
    int n;
    case (sbe_pkg::op_e'(op))
      sbe_pkg::OP_READ:      return !stored(a) || written[a];
      sbe_pkg::OP_DROP_ONE, sbe_pkg::OP_DROP_N: begin
        n = (sbe_pkg::op_e'(op) == sbe_pkg::OP_DROP_ONE) ? 1 : amt;
        return (n == 0) || (n >= track_len) || span_written(n + 1, track_len);
      end
      sbe_pkg::OP_SWAP:
        return !stored(a) || !stored(b) || (written[a] && written[b]);
      sbe_pkg::OP_UP_EQ, sbe_pkg::OP_UP_NE, sbe_pkg::OP_DN_EQ, sbe_pkg::OP_DN_NE,
      sbe_pkg::OP_REVERSE, sbe_pkg::OP_SHIFT_R, sbe_pkg::OP_SHIFT_L:
        return span_written(a, b);
      default:               return 1'b1;
    endcase
  endfunction

  // Updates the written map and length as the operation will.
  function automatic void note_effects(logic [3:0] op, int a, int b, int amt);
    int n;
    case (sbe_pkg::op_e'(op))
      sbe_pkg::OP_SET_LEN: track_len = (amt > Cap) ? Cap : amt;
      sbe_pkg::OP_WRITE:   if (stored(a)) written[a] = 1'b1;
      sbe_pkg::OP_DROP_ONE, sbe_pkg::OP_DROP_N: begin
        n = (sbe_pkg::op_e'(op) == sbe_pkg::OP_DROP_ONE) ? 1 : amt;
        if (n != 0) begin
          for (int i = 1; i <= track_len - n; i++) written[i] = 1'b1;
          track_len = (n >= track_len) ? 0 : track_len - n;
        end
      end
      sbe_pkg::OP_SHIFT_R: begin
        for (int k = 0; k < b - a + 1; k++)
          if (stored(b + amt - k) && stored(b - k)) written[b + amt - k] = 1'b1;
      end
      sbe_pkg::OP_SHIFT_L: begin
        for (int k = 0; k < b - a + 1; k++)
          if (stored(a - amt + k) && stored(a + k)) written[a - amt + k] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Offers one item after a random gap and returns once it is accepted.
  task automatic issue(logic [3:0] op, int a, int b, int amt, logic [31:0] v);
    int gap;
    note_effects(op, a, b, amt);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation  <= op;
    index_a    <= 11'(a);
    index_b    <= 11'(b);
    amount     <= 11'(amt);
    data_value <= v;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Positions cluster near both ends so that ranges are often fully written.
  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return $urandom_range(1017, 1025);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    return ($urandom_range(0, 2) != 0) ? value_pool[$urandom_range(0, 3)] : $urandom;
  endfunction

  task automatic random_item();
    logic [3:0] op;
    int         a;
    int         b;
    int         amt;
    logic [31:0] v;
    op  = ($urandom_range(0, 3) == 0) ? 4'(sbe_pkg::OP_WRITE) : 4'($urandom_range(0, 15));
    a   = pick_pos();
    b   = ($urandom_range(0, 5) == 0) ? pick_pos() : a + $urandom_range(0, 10);
    if (b > 1025) b = 1025;
    case ($urandom_range(0, 7))
      0:       amt = Cap;
      1:       amt = $urandom_range(0, Cap);
      default: amt = $urandom_range(0, 8);
    endcase
    if (sbe_pkg::op_e'(op) == sbe_pkg::OP_SET_LEN && amt > 40 && amt < Cap)
      amt = $urandom_range(0, 40);
    v = pick_value();
    // An item that would touch unwritten storage becomes a write instead.
    if (!reads_ok(op, a, b, amt)) begin
      op = 4'(sbe_pkg::OP_WRITE);
      a  = pick_pos();
      if (!stored(a)) a = 1;
    end
    issue(op, a, b, amt, v);
  endtask

  // Result side: random hold-off per result, with one long stretch on request.
  initial begin
    int   wait_cycles;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        wait_cycles = 400;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    for (int p = 1; p <= Cap; p++) written[p] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, out-of-range positions, every operation, empty ranges.
    issue(sbe_pkg::OP_WRITE, 1, 0, 0, 32'h8000_0000);
    issue(sbe_pkg::OP_WRITE, 2, 0, 0, 32'h7fff_ffff);
    issue(sbe_pkg::OP_WRITE, 3, 0, 0, 32'h0000_0001);
    issue(sbe_pkg::OP_WRITE, Cap, 0, 0, 32'hffff_ffff);
    issue(sbe_pkg::OP_WRITE, 0, 0, 0, 32'h1234_5678);
    issue(sbe_pkg::OP_WRITE, 1025, 0, 0, 32'h1234_5678);
    issue(sbe_pkg::OP_READ, 1, 0, 0, 0);
    issue(sbe_pkg::OP_READ, 0, 0, 0, 0);
    issue(sbe_pkg::OP_READ, 1025, 0, 0, 0);
    issue(sbe_pkg::OP_SET_LEN, 0, 0, Cap, 0);
    issue(sbe_pkg::OP_SET_LEN, 0, 0, 3, 0);
    issue(sbe_pkg::OP_DROP_N, 0, 0, 5, 0);
    issue(sbe_pkg::OP_SWAP, 0, 2, 0, 0);
    issue(sbe_pkg::OP_SWAP, 1, 2, 0, 0);
    issue(sbe_pkg::OP_UP_EQ, 0, 3, 0, 32'h5555_5555);
    issue(sbe_pkg::OP_UP_NE, 1, 3, 0, 32'h7fff_ffff);
    issue(sbe_pkg::OP_DN_EQ, 0, 3, 0, 32'h8000_0000);
    issue(sbe_pkg::OP_DN_NE, 3, 1, 0, 32'h0);
    issue(sbe_pkg::OP_UP_EQ, 1025, 1024, 0, 32'hffff_ffff);
    issue(sbe_pkg::OP_REVERSE, 0, 3, 0, 0);
    issue(sbe_pkg::OP_SHIFT_R, 1, 2, 1, 0);
    issue(sbe_pkg::OP_SHIFT_L, 2, 3, 1, 0);
    issue(sbe_pkg::OP_SHIFT_L, 2, 1, 1, 0);
    issue(4'd13, 0, 0, 0, 0);
    issue(4'd15, 2047, 2047, 2047, 32'hffff_ffff);
    issue(sbe_pkg::OP_DROP_ONE, 0, 0, 0, 0);

    // Random part with a long result hold-off and a full drain along the way.
    for (int n = 0; n < 264; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 200) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_item();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bounded_sequence_engine");
    end else begin
      $display("FAIL bounded_sequence_engine");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sbe_pkg.sv
rtl/core/sbe_mem.sv
rtl/core/bounded_sequence_engine.sv
tb/seq_result_checker.sv
tb/tb.sv
